/* src/wlce_pkg.sv */
package wlce_pkg;

  localparam int NPTS   = 1024;
  localparam int NDIM   = 16;
  localparam int IDX_W  = 10;
  localparam int DIM_W  = 4;
  localparam int ADDR_W = IDX_W + DIM_W;
  localparam int CRD_W  = 16;
  localparam int SZ_W   = 11;
  localparam int SUM_W  = SZ_W + 1;
  localparam int DIST_W = 47;
  localparam int ACC_W  = 37;
  localparam int NUM_W  = 64;
  localparam int MAG_W  = 28;
  localparam int CFG_W  = 5;
  localparam int OP_W   = 3;
  localparam int STEP_W = 5;

  localparam logic [OP_W-1:0] OP_WCOORD = 3'd0;
  localparam logic [OP_W-1:0] OP_WSIZE  = 3'd1;
  localparam logic [OP_W-1:0] OP_SQ     = 3'd2;
  localparam logic [OP_W-1:0] OP_WARD   = 3'd3;
  localparam logic [OP_W-1:0] OP_MERGE  = 3'd4;

  localparam logic [CFG_W-1:0]  DIM_RESET   = 5'd16;
  localparam logic [STEP_W-1:0] WARD_STEPS  = 5'd16;
  localparam logic [STEP_W-1:0] MERGE_STEPS = 5'd7;

  typedef struct packed {
    logic latch;
    logic wr_coord;
    logic wr_size;
    logic size_rd;
    logic k_clr;
    logic k_inc;
    logic rd_issue;
    logic diff_ld;
    logic acc_clr;
    logic acc_add;
    logic m_ld;
    logic p_lo;
    logic p_hi;
    logic div_ward;
    logic div_merge;
    logic ma_ld;
    logic mb_add;
    logic wr_merge;
    logic wr_merge_size;
    logic load_out;
    logic out_ward;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic k_last;
    logic s_zero;
    logic ward_zero;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

/* src/ward_linkage_centroid_engine.sv */
// ward linkage centroid engine
// keeps a centroid table (16 signed q8.8 coordinates per cluster) and a
// cluster size table for ward clustering
// input channel: in_valid / in_stall, one item per accept carrying opcode,
//   indexes, a coordinate value and a size value
// result channel: out_valid / out_stall, one item per distance query
// config channel: cfg_valid / cfg_ready, sets dimensions_in_use (reset 16)
// steps per item, with n used dimensions:
//   coordinate or size write: latch, then write
//   squared distance: one read, one abs and one square-accumulate per
//     dimension
//   ward distance: adds a size product, two partial products, a divide
//     start and a radix-16 divide by the size sum
//   merge: a read, two weighted products, a divide start and a divide
//     per dimension, then the size update
// items are taken one at a time; a finished result sits in the output
// register so the next item is accepted while the receiver stalls
// reset clears the controller and sets dimensions to 16; the stores are
// not cleared, entries must be written before they are read
module ward_linkage_centroid_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [wlce_pkg::OP_W-1:0]            in_opcode,
  input  logic [wlce_pkg::IDX_W-1:0]           in_first_index,
  input  logic [wlce_pkg::IDX_W-1:0]           in_second_index,
  input  logic [wlce_pkg::DIM_W-1:0]           in_coordinate_index,
  input  logic signed [wlce_pkg::CRD_W-1:0]    in_coordinate_value,
  input  logic [wlce_pkg::SZ_W-1:0]            in_size_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wlce_pkg::DIST_W-1:0]          out_distance_value,
  output logic                                 out_was_ward,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wlce_pkg::CFG_W-1:0]           cfg_data
);

  wlce_pkg::cmd_t    cmd;
  wlce_pkg::status_t st;

  // config writes are registered directly, always taken
  assign cfg_ready = 1'b1;

  // sequencer: decodes the item and steps the datapath
  wlce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // stores, arithmetic, divider and result register
  wlce_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .cfg_valid           (cfg_valid),
    .cfg_data            (cfg_data),
    .in_first_index      (in_first_index),
    .in_second_index     (in_second_index),
    .in_coordinate_index (in_coordinate_index),
    .in_coordinate_value (in_coordinate_value),
    .in_size_value       (in_size_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_distance_value  (out_distance_value),
    .out_was_ward        (out_was_ward)
  );

endmodule

/* src/wlce_div.sv */
module wlce_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [wlce_pkg::STEP_W-1:0]          steps,
  input  logic [wlce_pkg::NUM_W-1:0]           num,
  input  logic [wlce_pkg::SUM_W-1:0]           den,
  output logic                                 done,
  output logic [wlce_pkg::NUM_W-1:0]           quo
);

  logic [wlce_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [wlce_pkg::NUM_W-1:0]  num_r, num_nxt;
  logic [wlce_pkg::SUM_W-1:0]  rem_r, rem_nxt;
  logic [wlce_pkg::SUM_W-1:0]  den_r;
  logic [wlce_pkg::SUM_W:0]    trial;
  logic [wlce_pkg::NUM_W-1:0]  n_w;
  logic [wlce_pkg::SUM_W-1:0]  r_w;

  // four restoring steps per cycle
  always_comb begin
    n_w = num_r;
    r_w = rem_r;
    trial = '0;
    for (int b = 0; b < 4; b++) begin
      trial = {r_w, n_w[wlce_pkg::NUM_W-1]};
      n_w   = {n_w[wlce_pkg::NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        r_w    = wlce_pkg::SUM_W'(trial - {1'b0, den_r});
        n_w[0] = 1'b1;
      end else begin
        r_w = trial[wlce_pkg::SUM_W-1:0];
      end
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      num_nxt  = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = n_w;
      rem_nxt = r_w;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

/* src/wlce_dpath.sv */
module wlce_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wlce_pkg::cmd_t                       cmd,
  output wlce_pkg::status_t                    st,
  input  logic                                 cfg_valid,
  input  logic [wlce_pkg::CFG_W-1:0]           cfg_data,
  input  logic [wlce_pkg::IDX_W-1:0]           in_first_index,
  input  logic [wlce_pkg::IDX_W-1:0]           in_second_index,
  input  logic [wlce_pkg::DIM_W-1:0]           in_coordinate_index,
  input  logic signed [wlce_pkg::CRD_W-1:0]    in_coordinate_value,
  input  logic [wlce_pkg::SZ_W-1:0]            in_size_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wlce_pkg::DIST_W-1:0]          out_distance_value,
  output logic                                 out_was_ward
);

  localparam int NMEM = wlce_pkg::NPTS * wlce_pkg::NDIM;

  logic [wlce_pkg::CRD_W-1:0] cmem [NMEM];
  logic [wlce_pkg::SZ_W-1:0]  smem [wlce_pkg::NPTS];

  logic [wlce_pkg::CFG_W-1:0] dims_r;
  logic [wlce_pkg::IDX_W-1:0] i_r, j_r;
  logic [wlce_pkg::DIM_W-1:0] c_r, k_r;
  logic signed [wlce_pkg::CRD_W-1:0] val_r;
  logic [wlce_pkg::SZ_W-1:0] sz_r, ni_q, nj_q;
  logic signed [wlce_pkg::CRD_W-1:0] a_q, b_q;
  logic [wlce_pkg::CRD_W-1:0] mag_r;
  logic [wlce_pkg::ACC_W-1:0] acc_r;
  logic [22:0] m_r;
  logic [wlce_pkg::NUM_W-1:0] p_r;
  logic signed [wlce_pkg::MAG_W:0] t_r;
  logic [wlce_pkg::CFG_W-1:0] n_use;
  logic [wlce_pkg::SUM_W-1:0] s_w;
  logic signed [wlce_pkg::CRD_W:0] diff_w;
  logic [wlce_pkg::MAG_W-1:0] tmag_w;
  logic [wlce_pkg::NUM_W-1:0] div_num, quo;
  logic div_start, div_done;
  logic [wlce_pkg::STEP_W-1:0] div_steps;
  logic [wlce_pkg::CRD_W-1:0] mq_w;
  logic [wlce_pkg::ADDR_W-1:0] waddr;
  logic [wlce_pkg::CRD_W-1:0] wdata;
  logic [wlce_pkg::IDX_W-1:0] saddr;
  logic [wlce_pkg::SZ_W-1:0] sdata;
  logic out_valid_r;
  logic [wlce_pkg::DIST_W-1:0] dist_r, dist_w;
  logic ward_r;

  assign n_use  = (dims_r > wlce_pkg::CFG_W'(wlce_pkg::NDIM)) ?
                  wlce_pkg::CFG_W'(wlce_pkg::NDIM) : dims_r;
  assign s_w    = {1'b0, ni_q} + {1'b0, nj_q};
  assign diff_w = (wlce_pkg::CRD_W+1)'(a_q) - (wlce_pkg::CRD_W+1)'(b_q);
  assign tmag_w = t_r[wlce_pkg::MAG_W] ? wlce_pkg::MAG_W'(-t_r) : t_r[wlce_pkg::MAG_W-1:0];
  assign mq_w   = t_r[wlce_pkg::MAG_W] ? wlce_pkg::CRD_W'(-quo[wlce_pkg::CRD_W-1:0]) :
                  quo[wlce_pkg::CRD_W-1:0];

  assign st.n_zero    = (n_use == '0);
  assign st.k_last    = ({1'b0, k_r} == n_use - 1'b1);
  assign st.s_zero    = (s_w == '0);
  assign st.ward_zero = (ni_q == '0) || (nj_q == '0);
  assign st.div_done  = div_done;
  assign st.out_busy  = out_valid_r && out_stall;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= wlce_pkg::DIM_RESET;
    end else if (cfg_valid) begin
      dims_r <= cfg_data;
    end
  end

  // item capture and walk counter
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      i_r   <= in_first_index;
      j_r   <= in_second_index;
      c_r   <= in_coordinate_index;
      val_r <= in_coordinate_value;
      sz_r  <= in_size_value;
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + 1'b1;
    end
  end

  // centroid store, one write and two read ports
  always_comb begin
    if (cmd.wr_merge) begin
      waddr = {j_r, k_r};
      wdata = mq_w;
    end else begin
      waddr = {i_r, c_r};
      wdata = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_coord || cmd.wr_merge) begin
      cmem[waddr] <= wdata;
    end
    if (cmd.rd_issue) begin
      a_q <= cmem[{i_r, k_r}];
      b_q <= cmem[{j_r, k_r}];
    end
  end

  // size store
  always_comb begin
    if (cmd.wr_merge_size) begin
      saddr = j_r;
      sdata = s_w[wlce_pkg::SZ_W] ? {wlce_pkg::SZ_W{1'b1}} : s_w[wlce_pkg::SZ_W-1:0];
    end else begin
      saddr = i_r;
      sdata = sz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_size || cmd.wr_merge_size) begin
      smem[saddr] <= sdata;
    end
    if (cmd.size_rd) begin
      ni_q <= smem[i_r];
      nj_q <= smem[j_r];
    end
  end

  // arithmetic
  always_ff @(posedge clk) begin
    if (cmd.diff_ld) begin
      mag_r <= diff_w[wlce_pkg::CRD_W] ? wlce_pkg::CRD_W'(-diff_w) :
               diff_w[wlce_pkg::CRD_W-1:0];
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + wlce_pkg::ACC_W'(mag_r * mag_r);
    end
    if (cmd.m_ld) begin
      m_r <= {(2*wlce_pkg::SZ_W)'(ni_q) * (2*wlce_pkg::SZ_W)'(nj_q), 1'b0};
    end
    if (cmd.p_lo) begin
      p_r <= wlce_pkg::NUM_W'(m_r * acc_r[18:0]);
    end else if (cmd.p_hi) begin
      p_r <= p_r + (wlce_pkg::NUM_W'(m_r * acc_r[36:19]) << 19);
    end
    if (cmd.ma_ld) begin
      t_r <= (wlce_pkg::MAG_W+1)'(a_q * $signed({1'b0, ni_q}));
    end else if (cmd.mb_add) begin
      t_r <= t_r + (wlce_pkg::MAG_W+1)'(b_q * $signed({1'b0, nj_q}));
    end
  end

  assign div_start = cmd.div_ward || cmd.div_merge;
  assign div_steps = cmd.div_ward ? wlce_pkg::WARD_STEPS : wlce_pkg::MERGE_STEPS;
  assign div_num   = cmd.div_ward ? p_r :
                     {tmag_w, {(wlce_pkg::NUM_W-wlce_pkg::MAG_W){1'b0}}};

  wlce_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .steps (div_steps),
    .num   (div_num),
    .den   (s_w),
    .done  (div_done),
    .quo   (quo)
  );

  // result register
  always_comb begin
    if (!cmd.out_ward) begin
      dist_w = wlce_pkg::DIST_W'(acc_r);
    end else if (st.ward_zero) begin
      dist_w = '0;
    end else if (|quo[wlce_pkg::NUM_W-1:wlce_pkg::DIST_W]) begin
      dist_w = {wlce_pkg::DIST_W{1'b1}};
    end else begin
      dist_w = quo[wlce_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      dist_r <= dist_w;
      ward_r <= cmd.out_ward;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_distance_value = dist_r;
  assign out_was_ward       = ward_r;

endmodule

/* src/wlce_ctrl.sv */
module wlce_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [wlce_pkg::OP_W-1:0]    in_opcode,
  output logic                         in_stall,
  input  wlce_pkg::status_t            st,
  output wlce_pkg::cmd_t               cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_WC   = 5'd1;
  localparam logic [4:0] S_WS   = 5'd2;
  localparam logic [4:0] S_SIZE = 5'd3;
  localparam logic [4:0] S_CHK  = 5'd4;
  localparam logic [4:0] S_RD   = 5'd5;
  localparam logic [4:0] S_DIFF = 5'd6;
  localparam logic [4:0] S_ACC  = 5'd7;
  localparam logic [4:0] S_M1   = 5'd8;
  localparam logic [4:0] S_PLO  = 5'd9;
  localparam logic [4:0] S_PHI  = 5'd10;
  localparam logic [4:0] S_WST  = 5'd11;
  localparam logic [4:0] S_WDIV = 5'd12;
  localparam logic [4:0] S_MA   = 5'd13;
  localparam logic [4:0] S_MB   = 5'd14;
  localparam logic [4:0] S_MST  = 5'd15;
  localparam logic [4:0] S_MDIV = 5'd16;
  localparam logic [4:0] S_MSZ  = 5'd17;
  localparam logic [4:0] S_PUSH = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic [wlce_pkg::OP_W-1:0] op_r, op_nxt;
  logic accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.out_ward = (op_r == wlce_pkg::OP_WARD);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          op_nxt    = in_opcode;
          case (in_opcode)
            wlce_pkg::OP_WCOORD: state_nxt = S_WC;
            wlce_pkg::OP_WSIZE:  state_nxt = S_WS;
            wlce_pkg::OP_SQ,
            wlce_pkg::OP_WARD,
            wlce_pkg::OP_MERGE:  state_nxt = S_SIZE;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_WC: begin
        cmd.wr_coord = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_WS: begin
        cmd.wr_size = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SIZE: begin
        cmd.size_rd = 1'b1;
        cmd.k_clr   = 1'b1;
        cmd.acc_clr = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        if (op_r == wlce_pkg::OP_MERGE) begin
          state_nxt = (st.s_zero || st.n_zero) ? S_MSZ : S_RD;
        end else if (op_r == wlce_pkg::OP_WARD) begin
          if (st.ward_zero) begin
            state_nxt = S_PUSH;
          end else begin
            state_nxt = st.n_zero ? S_M1 : S_RD;
          end
        end else begin
          state_nxt = st.n_zero ? S_PUSH : S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = (op_r == wlce_pkg::OP_MERGE) ? S_MA : S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_ld = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        cmd.k_inc   = 1'b1;
        if (st.k_last) begin
          state_nxt = (op_r == wlce_pkg::OP_WARD) ? S_M1 : S_PUSH;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_M1: begin
        cmd.m_ld  = 1'b1;
        state_nxt = S_PLO;
      end
      S_PLO: begin
        cmd.p_lo  = 1'b1;
        state_nxt = S_PHI;
      end
      S_PHI: begin
        cmd.p_hi  = 1'b1;
        state_nxt = S_WST;
      end
      S_WST: begin
        cmd.div_ward = 1'b1;
        state_nxt    = S_WDIV;
      end
      S_WDIV: begin
        if (st.div_done) state_nxt = S_PUSH;
      end
      S_MA: begin
        cmd.ma_ld = 1'b1;
        state_nxt = S_MB;
      end
      S_MB: begin
        cmd.mb_add = 1'b1;
        state_nxt  = S_MST;
      end
      S_MST: begin
        cmd.div_merge = 1'b1;
        state_nxt     = S_MDIV;
      end
      S_MDIV: begin
        if (st.div_done) begin
          cmd.wr_merge = 1'b1;
          cmd.k_inc    = 1'b1;
          state_nxt    = st.k_last ? S_MSZ : S_RD;
        end
      end
      S_MSZ: begin
        cmd.wr_merge_size = 1'b1;
        state_nxt         = S_IDLE;
      end
      S_PUSH: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= wlce_pkg::OP_WCOORD;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !st.out_busy) else $error("result loaded over a held item");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_coord, cmd.wr_merge})) else $error("centroid write port conflict");

  a_query_walk: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_opcode == wlce_pkg::OP_SQ || in_opcode == wlce_pkg::OP_WARD)
    |=> state_r == S_SIZE) else $error("query did not start size read");

  a_ward_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_ward |-> op_r == wlce_pkg::OP_WARD) else $error("ward divide on wrong opcode");

endmodule
